[hw/rtl/icfr_pkg.sv]
`timescale 1ns / 1ps

package icfr_pkg;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  data_byte;
        logic [15:0] read_address;
    } req_t;

    typedef struct packed {
        logic [2:0] resp_kind;
        logic [9:0] chunks_present;
        logic [7:0] read_byte;
        logic       read_chunk_flag;
    } rsp_t;

    typedef struct packed {
        logic        resp;
        logic [2:0]  kind;
        logic        wr;
        logic        mark;
        logic        rd;
        logic [7:0]  wr_data;
        logic [15:0] store_addr;
        logic [15:0] chunk_src;
    } op_t;

    localparam logic [2:0] KIND_TLM    = 3'd0;
    localparam logic [2:0] KIND_STORED = 3'd1;
    localparam logic [2:0] KIND_REJECT = 3'd2;
    localparam logic [2:0] KIND_OTHER  = 3'd3;
    localparam logic [2:0] KIND_READ   = 3'd4;

    localparam logic [1:0] CLASS_OTHER = 2'd0;
    localparam logic [1:0] CLASS_TLM   = 2'd1;
    localparam logic [1:0] CLASS_IMG   = 2'd2;

    localparam logic [7:0] TYPE_TLM   = 8'h84;
    localparam logic [7:0] TYPE_IMG_A = 8'h01;
    localparam logic [7:0] TYPE_IMG_B = 8'h02;

    localparam int unsigned TYPE_POS    = 4;
    localparam int unsigned OFS_LO_POS  = 9;
    localparam int unsigned OFS_HI_POS  = 10;
    localparam int unsigned PAYLOAD_POS = 12;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;

    localparam logic [9:0] COUNT_MAX = 10'h3FF;

endpackage

[hw/rtl/icfr_front.sv]
`timescale 1ns / 1ps

module icfr_front
    import icfr_pkg::*;
#(
    parameter int FRAME_BYTES = 70,
    parameter int CHUNK_BYTES = 56,
    parameter int CHUNK_COUNT = 878
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  req_t req,
    input  logic busy,
    input  logic q_ready,
    output logic req_stall,
    output logic push,
    output op_t  push_op
);

    localparam int PosW = $clog2(FRAME_BYTES);
    localparam logic [PosW-1:0] TypePos = PosW'(TYPE_POS);
    localparam logic [PosW-1:0] OfsLoPos = PosW'(OFS_LO_POS);
    localparam logic [PosW-1:0] OfsHiPos = PosW'(OFS_HI_POS);
    localparam logic [PosW-1:0] PayPos = PosW'(PAYLOAD_POS);
    localparam logic [PosW-1:0] PayEnd = PosW'(PAYLOAD_POS + CHUNK_BYTES);
    localparam logic [PosW-1:0] LastPos = PosW'(FRAME_BYTES - 1);
    localparam logic [16:0] StoreLim = 17'(CHUNK_COUNT * CHUNK_BYTES);
    localparam logic [15:0] MaxOfs = 16'((CHUNK_COUNT - 1) * CHUNK_BYTES);

    logic [PosW-1:0] pos_reg;
    logic [PosW-1:0] pos_next;
    logic [1:0]      class_reg;
    logic [1:0]      class_next;
    logic [15:0]     ofs_reg;
    logic [15:0]     ofs_next;
    logic            img;
    logic            ofs_ok;
    logic            in_pay;
    logic            last;
    logic [16:0]     wr_addr;
    logic [2:0]      end_kind;
    logic            accept;
    logic            need;

    always_comb
    begin
        class_next = class_reg;
        if (pos_reg == TypePos)
        begin
            unique case (req.data_byte) inside
                TYPE_TLM:               class_next = CLASS_TLM;
                TYPE_IMG_A, TYPE_IMG_B: class_next = CLASS_IMG;
                default:                class_next = CLASS_OTHER;
            endcase
        end

        ofs_next = ofs_reg;
        if (pos_reg == OfsLoPos)
        begin
            ofs_next = {ofs_reg[15:8], req.data_byte};
        end
        else if (pos_reg == OfsHiPos)
        begin
            ofs_next = {req.data_byte, ofs_reg[7:0]};
        end

        img     = (class_next == CLASS_IMG);
        ofs_ok  = (ofs_next <= MaxOfs);
        in_pay  = (pos_reg >= PayPos) && (pos_reg < PayEnd);
        wr_addr = {1'b0, ofs_next} + 17'(pos_reg - PayPos);
        last    = (pos_reg == LastPos);
        pos_next = last ? '0 : pos_reg + PosW'(1);

        unique case (class_next)
            CLASS_TLM: end_kind = KIND_TLM;
            CLASS_IMG: end_kind = ofs_ok ? KIND_STORED : KIND_REJECT;
            default:   end_kind = KIND_OTHER;
        endcase

        if (req.cmd)
        begin
            push_op.resp       = 1'b1;
            push_op.kind       = KIND_READ;
            push_op.wr         = 1'b0;
            push_op.mark       = 1'b0;
            push_op.rd         = ({1'b0, req.read_address} < StoreLim);
            push_op.wr_data    = req.data_byte;
            push_op.store_addr = req.read_address;
            push_op.chunk_src  = req.read_address;
        end
        else
        begin
            push_op.resp       = last;
            push_op.kind       = end_kind;
            push_op.wr         = img && ofs_ok && in_pay && (wr_addr < StoreLim);
            push_op.mark       = last && img && ofs_ok;
            push_op.rd         = 1'b0;
            push_op.wr_data    = req.data_byte;
            push_op.store_addr = wr_addr[15:0];
            push_op.chunk_src  = ofs_next;
        end

        need = req.cmd || push_op.wr || last;
    end

    assign req_stall = busy || !q_ready;
    assign accept    = req_valid && !req_stall;
    assign push      = accept && need;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            class_reg <= CLASS_OTHER;
            ofs_reg   <= '0;
        end
        else if (accept && !req.cmd)
        begin
            pos_reg   <= pos_next;
            class_reg <= class_next;
            ofs_reg   <= ofs_next;
        end
    end

endmodule

[hw/rtl/icfr_queue.sv]
`timescale 1ns / 1ps

module icfr_queue
    import icfr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    output logic ready,
    input  logic pop,
    output logic head_valid,
    output op_t  head_op
);

    op_t                entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W:0]    cnt_reg;
    logic [QPTR_W:0]    cnt_next;

    assign ready      = (cnt_reg != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_op    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + (QPTR_W + 1)'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

[hw/rtl/icfr_back.sv]
`timescale 1ns / 1ps

module icfr_back
    import icfr_pkg::*;
#(
    parameter int CHUNK_BYTES = 56,
    parameter int CHUNK_COUNT = 878
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    input  op_t  q_op,
    output logic pop,
    output logic busy,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int StoreBytes = CHUNK_COUNT * CHUNK_BYTES;
    localparam int StoreAw = (StoreBytes > 1) ? $clog2(StoreBytes) : 1;
    localparam int ChunkAw = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;
    localparam int DivShift = 22;
    localparam int MulW = DivShift + 1;
    localparam int ProdW = 16 + MulW;
    localparam logic [MulW-1:0] DivMul =
        MulW'(((64'd1 << DivShift) + 64'(CHUNK_BYTES) - 64'd1) / 64'(CHUNK_BYTES));
    localparam logic [StoreAw-1:0] ClrLast = StoreAw'(StoreBytes - 1);
    localparam logic [StoreAw:0] ChunkLim = (StoreAw + 1)'(CHUNK_COUNT);

    logic [7:0]          store_mem [StoreBytes];
    logic                bitmap_mem [CHUNK_COUNT];

    logic                clr_busy_reg;
    logic [StoreAw-1:0]  clr_idx_reg;

    logic                adv;
    logic [ProdW-1:0]    prod_next;
    logic [ChunkAw-1:0]  chunk_idx;

    logic                s1_valid_reg;
    op_t                 s1_op_reg;
    logic [ProdW-1:0]    s1_prod_reg;
    logic [7:0]          s1_byte_reg;

    logic                s2_valid_reg;
    op_t                 s2_op_reg;
    logic [7:0]          s2_byte_reg;
    logic                s2_bit_reg;

    logic                out_valid_reg;
    rsp_t                out_reg;
    rsp_t                out_next;
    logic [9:0]          count_reg;
    logic [9:0]          count_next;

    assign busy      = clr_busy_reg;
    assign adv       = !(out_valid_reg && rsp_stall);
    assign pop       = q_valid && adv && !clr_busy_reg;
    assign prod_next = ProdW'(q_op.chunk_src) * ProdW'(DivMul);
    assign chunk_idx = s1_prod_reg[DivShift +: ChunkAw];
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        count_next = count_reg;
        if (s2_valid_reg && s2_op_reg.mark && !s2_bit_reg && (count_reg != COUNT_MAX))
        begin
            count_next = count_reg + 10'd1;
        end
        out_next.resp_kind       = s2_op_reg.kind;
        out_next.chunks_present  = count_next;
        out_next.read_byte       = s2_op_reg.rd ? s2_byte_reg : 8'd0;
        out_next.read_chunk_flag = s2_op_reg.rd && s2_bit_reg;
    end

    // clear sweep over the store and bitmap after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_idx_reg <= clr_idx_reg + StoreAw'(1);
            if (clr_idx_reg == ClrLast)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            store_mem[clr_idx_reg] <= 8'd0;
        end
        else if (pop && q_op.wr)
        begin
            store_mem[q_op.store_addr[StoreAw-1:0]] <= q_op.wr_data;
        end
        if (pop)
        begin
            s1_byte_reg <= store_mem[q_op.store_addr[StoreAw-1:0]];
        end
    end

    // read old flag and set it in the same cycle
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            if ({1'b0, clr_idx_reg} < ChunkLim)
            begin
                bitmap_mem[clr_idx_reg[ChunkAw-1:0]] <= 1'b0;
            end
        end
        else if (adv && s1_valid_reg && s1_op_reg.mark)
        begin
            bitmap_mem[chunk_idx] <= 1'b1;
        end
        if (adv && s1_valid_reg)
        begin
            s2_bit_reg <= bitmap_mem[chunk_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg   <= q_op;
            s1_prod_reg <= prod_next;
            s2_op_reg   <= s1_op_reg;
            s2_byte_reg <= s1_byte_reg;
            out_reg     <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= pop;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg && s2_op_reg.resp;
            count_reg     <= count_next;
        end
    end

endmodule

[hw/rtl/image_chunk_frame_reassembler.sv]
`timescale 1ns / 1ps
// Channel | Valid     | Stall      | Word            | Direction
// req     | req_valid | req_stall  | req (req_t)     | into block
// rsp     | rsp_valid | rsp_stall  | rsp (rsp_t)     | out of block
//
// One word per cycle while req_stall is low; a response passes through the queue,
// s1, s2 and output registers before rsp_valid rises. The image store and the chunk
// bitmap are each read and written in the same cycle. After reset a clear sweep zeroes
// the bitmap and all CHUNK_COUNT*CHUNK_BYTES (49168 by default) store bytes while
// req_stall is high. rsp_stall freezes the back pipeline; a four-word queue buffers req.

module image_chunk_frame_reassembler
    import icfr_pkg::*;
#(
    parameter int FRAME_BYTES = 70,
    parameter int CHUNK_BYTES = 56,
    parameter int CHUNK_COUNT = 878
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic busy;
    logic q_ready;
    logic push;
    op_t  push_op;
    logic pop;
    logic head_valid;
    op_t  head_op;

    icfr_front #(
        .FRAME_BYTES (FRAME_BYTES),
        .CHUNK_BYTES (CHUNK_BYTES),
        .CHUNK_COUNT (CHUNK_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .busy      (busy),
        .q_ready   (q_ready),
        .req_stall (req_stall),
        .push      (push),
        .push_op   (push_op)
    );

    icfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .ready      (q_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    icfr_back #(
        .CHUNK_BYTES (CHUNK_BYTES),
        .CHUNK_COUNT (CHUNK_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (head_valid),
        .q_op      (head_op),
        .pop       (pop),
        .busy      (busy),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

[tb/tb_image_chunk_frame_reassembler.sv]
`timescale 1ns / 1ps

module tb_image_chunk_frame_reassembler;
    import icfr_pkg::*;

    localparam int FRAME_BYTES  = 70;
    localparam int CHUNK_BYTES  = 56;
    localparam int CHUNK_COUNT  = 878;
    localparam int STORE_BYTES  = CHUNK_COUNT * CHUNK_BYTES;
    localparam int MAX_OFFSET   = (CHUNK_COUNT - 1) * CHUNK_BYTES;
    localparam logic CMD_BYTE   = 1'b0;
    localparam logic CMD_READ   = 1'b1;
    localparam int TARGET_WORDS = 1550;
    localparam int IDLE_PCT     = 11;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_LIMIT  = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    req_t pending_words[$];
    rsp_t expected_rsps[$];
    int unsigned stored_offsets[$];

    int unsigned frame_pos;
    logic [1:0]  frame_class;
    logic [15:0] frame_offset;
    logic [7:0]  image_mem [STORE_BYTES];
    bit          chunk_seen [CHUNK_COUNT];
    logic [9:0]  chunk_total;

    int accepted_words = 0;
    int received_rsps = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    image_chunk_frame_reassembler #(
        .FRAME_BYTES(FRAME_BYTES),
        .CHUNK_BYTES(CHUNK_BYTES),
        .CHUNK_COUNT(CHUNK_COUNT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic absorb_word(input req_t w);
        rsp_t r;
        int unsigned a;
        int unsigned c;
        r = '0;
        if (w.cmd == CMD_BYTE)
        begin
            if (frame_pos == TYPE_POS)
            begin
                if (w.data_byte == TYPE_TLM)
                    frame_class = CLASS_TLM;
                else if (w.data_byte == TYPE_IMG_A || w.data_byte == TYPE_IMG_B)
                    frame_class = CLASS_IMG;
                else
                    frame_class = CLASS_OTHER;
            end
            else if (frame_pos == OFS_LO_POS)
                frame_offset[7:0] = w.data_byte;
            else if (frame_pos == OFS_HI_POS)
                frame_offset[15:8] = w.data_byte;

            if (frame_class == CLASS_IMG && frame_offset <= MAX_OFFSET &&
                frame_pos >= PAYLOAD_POS && frame_pos < PAYLOAD_POS + CHUNK_BYTES)
            begin
                a = frame_offset + frame_pos - PAYLOAD_POS;
                if (a < STORE_BYTES)
                    image_mem[a] = w.data_byte;
            end

            if (frame_pos + 1 >= FRAME_BYTES)
            begin
                if (frame_class == CLASS_TLM)
                    r.resp_kind = KIND_TLM;
                else if (frame_class == CLASS_IMG)
                begin
                    if (frame_offset <= MAX_OFFSET)
                    begin
                        r.resp_kind = KIND_STORED;
                        c = frame_offset / CHUNK_BYTES;
                        if (c < CHUNK_COUNT && !chunk_seen[c])
                        begin
                            chunk_seen[c] = 1'b1;
                            if (chunk_total != COUNT_MAX)
                                chunk_total = chunk_total + 10'd1;
                        end
                    end
                    else
                        r.resp_kind = KIND_REJECT;
                end
                else
                    r.resp_kind = KIND_OTHER;
                r.chunks_present = chunk_total;
                expected_rsps.push_back(r);
                frame_pos = 0;
            end
            else
                frame_pos = frame_pos + 1;
        end
        else
        begin
            r.resp_kind = KIND_READ;
            r.chunks_present = chunk_total;
            if (w.read_address < STORE_BYTES)
            begin
                r.read_byte = image_mem[w.read_address];
                r.read_chunk_flag = chunk_seen[w.read_address / CHUNK_BYTES];
            end
            expected_rsps.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch at cycle %0d, response %0d: %s", cycle_count,
                     received_rsps, msg);
        mismatch_count++;
    endtask

    task automatic check_rsp(input rsp_t got);
        rsp_t want;
        if (expected_rsps.size() == 0)
            report_mismatch($sformatf("unexpected word of kind %0d", got.resp_kind));
        else
        begin
            want = expected_rsps.pop_front();
            if (got.resp_kind !== want.resp_kind)
                report_mismatch($sformatf("resp_kind %0d, want %0d",
                                          got.resp_kind, want.resp_kind));
            if (got.chunks_present !== want.chunks_present)
                report_mismatch($sformatf("chunks_present %0d, want %0d",
                                          got.chunks_present, want.chunks_present));
            if (got.read_byte !== want.read_byte)
                report_mismatch($sformatf("read_byte %0h, want %0h",
                                          got.read_byte, want.read_byte));
            if (got.read_chunk_flag !== want.read_chunk_flag)
                report_mismatch($sformatf("read_chunk_flag %0d, want %0d",
                                          got.read_chunk_flag, want.read_chunk_flag));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                absorb_word(req);
                accepted_words++;
            end
            // hold the word while stalled
            if (!req_valid || !req_stall)
            begin
                if (pending_words.size() > 0 &&
                    ((accepted_words >= 500 && accepted_words < 850) ||
                     $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    req <= pending_words.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
            if (rsp_valid && !rsp_stall)
            begin
                check_rsp(rsp);
                received_rsps++;
            end
            rsp_stall <= !(received_rsps >= 60 && received_rsps < 140) &&
                         $urandom_range(0, 99) < IDLE_PCT;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        req_t w;
        w.cmd = CMD_BYTE;
        w.data_byte = b;
        w.read_address = 16'($urandom);
        pending_words.push_back(w);
    endtask

    task automatic push_read(input logic [15:0] a);
        req_t w;
        w.cmd = CMD_READ;
        w.data_byte = 8'($urandom);
        w.read_address = a;
        pending_words.push_back(w);
    endtask

    function automatic logic [15:0] pick_read_addr();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 5 && stored_offsets.size() > 0)
            return 16'(stored_offsets[$urandom_range(0, stored_offsets.size() - 1)] +
                       $urandom_range(0, 2 * CHUNK_BYTES - 1));
        else if (sel < 7)
            return 16'($urandom_range(STORE_BYTES - 64, STORE_BYTES + 8));
        else
            return 16'($urandom);
    endfunction

    task automatic push_frame(input logic [7:0] type_byte, input logic [15:0] ofs);
        logic [7:0] b;
        for (int p = 0; p < FRAME_BYTES; p++)
        begin
            if (p == TYPE_POS)
                b = type_byte;
            else if (p == OFS_LO_POS)
                b = ofs[7:0];
            else if (p == OFS_HI_POS)
                b = ofs[15:8];
            else
                b = 8'($urandom);
            push_byte(b);
            if ($urandom_range(0, 99) < 8)
                push_read(16'(ofs + $urandom_range(0, FRAME_BYTES - 3)));
        end
        if ((type_byte == TYPE_IMG_A || type_byte == TYPE_IMG_B) && ofs <= MAX_OFFSET)
            stored_offsets.push_back(ofs);
    endtask

    task automatic push_random_frame();
        int unsigned sel;
        logic [7:0] t;
        logic [15:0] ofs;
        sel = $urandom_range(0, 99);
        if (sel < 15)
            t = TYPE_TLM;
        else if (sel < 30)
            t = 8'($urandom);
        else if (sel < 65)
            t = TYPE_IMG_A;
        else
            t = TYPE_IMG_B;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            ofs = '0;
        else if (sel < 16)
            ofs = 16'(MAX_OFFSET);
        else if (sel < 26)
            ofs = 16'($urandom_range(MAX_OFFSET + 1, 65535));
        else if (sel < 46)
            ofs = 16'(CHUNK_BYTES * $urandom_range(0, CHUNK_COUNT - 1));
        else if (sel < 70 && stored_offsets.size() > 0)
            ofs = 16'(stored_offsets[$urandom_range(0, stored_offsets.size() - 1)]);
        else
            ofs = 16'($urandom_range(0, MAX_OFFSET));
        push_frame(t, ofs);
        repeat ($urandom_range(1, 6)) push_read(pick_read_addr());
    endtask

    initial
    begin
        foreach (image_mem[i])
            image_mem[i] = '0;
        foreach (chunk_seen[i])
            chunk_seen[i] = 1'b0;
        frame_pos = 0;
        frame_class = CLASS_OTHER;
        frame_offset = '0;
        chunk_total = '0;

        push_read(16'd0);
        push_read(16'(MAX_OFFSET));
        push_read(16'(STORE_BYTES - 1));
        push_read(16'(STORE_BYTES));
        push_read(16'hFFFF);

        push_frame(TYPE_IMG_A, 16'd0);
        push_frame(TYPE_IMG_B, 16'(MAX_OFFSET));
        push_frame(TYPE_IMG_A, 16'hFFFF);
        push_frame(TYPE_IMG_B, 16'(MAX_OFFSET + 1));
        push_frame(TYPE_TLM, 16'd0);
        push_frame(8'h00, 16'd0);
        push_frame(8'hFF, 16'd0);
        push_frame(TYPE_IMG_A, 16'(CHUNK_BYTES + 1));
        push_frame(TYPE_IMG_B, 16'd0);
        push_read(16'd0);
        push_read(16'(CHUNK_BYTES - 1));
        push_read(16'(CHUNK_BYTES));
        push_read(16'(2 * CHUNK_BYTES + 1));
        push_read(16'(STORE_BYTES - 1));

        while (pending_words.size() < TARGET_WORDS)
            push_random_frame();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() > 0 || req_valid)
            @(posedge clk);
        while (expected_rsps.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
